### design/rcfp_pkg.sv
package rcfp_pkg;

  // Byte buffer and frame layout
  localparam int BUF_DEPTH      = 32;
  localparam int CHANNEL_COUNT  = 14;
  localparam int FRAME_OVERHEAD = 3;
  localparam int MIN_FRAME_LEN  = FRAME_OVERHEAD + 1;

  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int POS_W  = $clog2(2 * CHANNEL_COUNT + 2);

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 16;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 16;
  localparam int MAXLEN_W = 6;

  localparam logic [SUM_W-1:0] CHECK_INIT = 16'hFFFF;

  // Configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_CMD     = 1'b1;

  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 6'd32;
  localparam logic [BYTE_W-1:0]   CMD_RESET     = 8'd64;

  typedef enum logic [3:0] {
    PH_DISCARD = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_CHK_LO  = 4'b0100,
    PH_CHK_HI  = 4'b1000
  } phase_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CMD_RD  = 6'b000010,
    ST_CMD_CMP = 6'b000100,
    ST_RD_LO   = 6'b001000,
    ST_RD_HI   = 6'b010000,
    ST_OUT     = 6'b100000
  } state_e;

endpackage

### design/rc_receiver_frame_parser.sv
// Frame parser for a serial radio receiver. Each request on the input stream is one
// received byte in s_axis_tdata with s_axis_tuser set when an idle gap came before it;
// such a byte opens a frame as its length byte. Accepted lengths run from four up to
// the max_frame_length register (address 0) and at most 35; the payload is buffered
// while a 16-bit checksum counts down from 0xFFFF, and the two checksum bytes follow,
// low byte first. When the checksum matches and payload byte 0 equals the command_code
// register (address 4), every channel goes out as one request: index in tdata[3:0], the
// little-endian 16-bit value in tdata[19:4], tlast on the final channel. Input is taken
// only in ST_IDLE. After a good frame's checksum the block is busy in ST_CMD_RD and
// ST_CMD_CMP to read back the command byte, then per channel in ST_RD_LO, ST_RD_HI
// and ST_OUT (plus any output stall): the byte buffer has a single registered read port
// and every channel needs two reads. Entries never written since reset read as zero.
module rc_receiver_frame_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] rx_byte
  input  logic                               s_axis_tuser,   // [0] gap_before
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [23:0]                        m_axis_tdata,   // [3:0] channel_index,
                                                             // [19:4] channel_value,
                                                             // [23:20] zero
  output logic                               m_axis_tlast,   // last_channel
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcfp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rcfp_pkg::*;

  // configuration
  logic [MAXLEN_W-1:0] max_len_q;
  logic [BYTE_W-1:0]   cmd_q;
  logic                cfg_wr;

  // parser state
  phase_e              phase_q, phase_d;
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    wr_pos_q, wr_pos_d;
  logic [CNT_W-1:0]    pay_len_q, pay_len_d;
  logic [SUM_W-1:0]    run_q, run_d;
  logic [BYTE_W-1:0]   chk_low_q, chk_low_d;

  // channel read-out
  logic [POS_W-1:0]    rd_pos_q, rd_pos_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic [BYTE_W-1:0]   lo_q, lo_d;

  // byte buffer
  logic [BYTE_W-1:0]   mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] valid_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_in_range;
  logic [BYTE_W-1:0]   rd_data_q;
  logic                rd_ok_q;
  logic [BYTE_W-1:0]   rd_byte;

  logic                in_acc;
  logic                out_acc;
  logic                len_ok;
  logic                last_chan;

  // Configuration port: zero wait states, decode on the word address bit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_MAX_LEN: prdata = 32'(max_len_q);
      REG_CMD:     prdata = 32'(cmd_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      cmd_q     <= CMD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_LEN) max_len_q <= pwdata[MAXLEN_W-1:0];
      if (paddr[2] == REG_CMD)     cmd_q     <= pwdata[BYTE_W-1:0];
    end
  end

  // Handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign last_chan     = (chan_q == CHAN_W'(CHANNEL_COUNT - 1));

  // The high byte sits on the read port for the whole output state: the read
  // position holds there and nothing is written while the input is blocked.
  assign m_axis_tdata = {4'd0, rd_byte, lo_q, chan_q};
  assign m_axis_tlast = last_chan;

  // Length byte sanity: at least one payload byte, within max_len_q and the buffer size.
  assign len_ok = (32'(s_axis_tdata) >= MIN_FRAME_LEN) &&
                  (s_axis_tdata <= 8'(max_len_q)) &&
                  (32'(s_axis_tdata) <= BUF_DEPTH + FRAME_OVERHEAD);

  // Buffer write: payload bytes land at the write position while it is inside the buffer.
  assign wr_addr = ADDR_W'(wr_pos_q);
  assign mem_we  = in_acc && !s_axis_tuser && (phase_q == PH_DATA) &&
                   (32'(wr_pos_q) < BUF_DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= s_axis_tdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // Buffer read: one registered port, addressed by the read position every cycle.
  // Unwritten entries and positions past the buffer read as zero.
  assign rd_addr     = ADDR_W'(rd_pos_q);
  assign rd_in_range = (32'(rd_pos_q) < BUF_DEPTH);

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= rd_in_range && valid_q[rd_addr];
    end
  end

  assign rd_byte = rd_ok_q ? rd_data_q : '0;

  // Sequencer
  always_comb begin
    phase_d   = phase_q;
    state_d   = state_q;
    wr_pos_d  = wr_pos_q;
    pay_len_d = pay_len_q;
    run_d     = run_q;
    chk_low_d = chk_low_q;
    rd_pos_d  = rd_pos_q;
    chan_d    = chan_q;
    lo_d      = lo_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            // A gap always ends the current frame: a sane byte opens a new one as its length.
            if (len_ok) begin
              wr_pos_d  = '0;
              pay_len_d = CNT_W'(32'(s_axis_tdata) - FRAME_OVERHEAD);
              run_d     = CHECK_INIT - SUM_W'(s_axis_tdata);
              phase_d   = PH_DATA;
            end else begin
              phase_d = PH_DISCARD;
            end
          end else begin
            unique case (phase_q)
              PH_DATA: begin
                wr_pos_d = wr_pos_q + CNT_W'(1);
                run_d    = run_q - SUM_W'(s_axis_tdata);
                if (wr_pos_d >= pay_len_q) phase_d = PH_CHK_LO;
              end
              PH_CHK_LO: begin
                chk_low_d = s_axis_tdata;
                phase_d   = PH_CHK_HI;
              end
              PH_CHK_HI: begin
                // Checksum good: fetch the command byte before emitting.
                if (run_q == {s_axis_tdata, chk_low_q}) begin
                  rd_pos_d = '0;
                  state_d  = ST_CMD_RD;
                end
                phase_d = PH_DISCARD;
              end
              default: phase_d = PH_DISCARD;
            endcase
          end
        end
      end
      ST_CMD_RD: begin
        state_d = ST_CMD_CMP;
      end
      ST_CMD_CMP: begin
        if (rd_byte == cmd_q) begin
          rd_pos_d = POS_W'(1);
          chan_d   = '0;
          state_d  = ST_RD_LO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_LO: begin
        // Low byte is being read; advance to the high byte.
        rd_pos_d = rd_pos_q + POS_W'(1);
        state_d  = ST_RD_HI;
      end
      ST_RD_HI: begin
        lo_d    = rd_byte;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last_chan) begin
            state_d = ST_IDLE;
          end else begin
            chan_d   = chan_q + CHAN_W'(1);
            rd_pos_d = rd_pos_q + POS_W'(1);
            state_d  = ST_RD_LO;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the low byte from the cycle the high-byte read is issued until the
  // channel is taken.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_HI) begin
      lo_q <= lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DISCARD;
      state_q   <= ST_IDLE;
      wr_pos_q  <= '0;
      pay_len_q <= '0;
      run_q     <= '0;
      chk_low_q <= '0;
      rd_pos_q  <= '0;
      chan_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      state_q   <= state_d;
      wr_pos_q  <= wr_pos_d;
      pay_len_q <= pay_len_d;
      run_q     <= run_d;
      chk_low_q <= chk_low_d;
      rd_pos_q  <= rd_pos_d;
      chan_q    <= chan_d;
    end
  end

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a channel is pending");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast |=> s_axis_tready)
    else $error("parser not idle after last channel");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(chan_q) < CHANNEL_COUNT))
    else $error("channel index out of range");
`endif

endmodule

### verif/tb.sv
module tb;
  import rcfp_pkg::*;

  // Cycles with no request on either stream before the run is called hung.
  // The slowest correct stretch is a sender gap, the command read-back and a
  // receiver stall back to back.
  localparam int QUIET_LIMIT = 2000;
  // Cycles to let the parser finish a command compare that yields nothing.
  localparam int SETTLE_CYCLES = 8;
  // Tail after the last channel: read-back plus one full channel burst.
  localparam int TAIL_CYCLES = 64;
  // Send every byte of a frame, checksum included.
  localparam int FULL_FRAME = 1000;

  // Byte addresses of the two registers.
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_CMD     = {REG_CMD, 2'b00};

  typedef struct packed {
    logic [CHAN_W-1:0]  index;
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } channel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] rx_byte
  logic                  s_axis_tuser = 1'b0; // [0] gap_before
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;        // [3:0] index, [19:4] value
  logic                  m_axis_tlast;        // last_channel
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  rc_receiver_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame parser mirror: register copies, parse state and the byte buffer,
  // advanced once per accepted input request.
  // ---------------------------------------------------------------------------
  logic [MAXLEN_W-1:0] cfg_max_len = MAX_LEN_RESET;
  logic [BYTE_W-1:0]   cfg_cmd     = CMD_RESET;

  phase_e              parse_phase = PH_DISCARD;
  int unsigned         fill_pos    = 0;
  int unsigned         payload_len = 0;
  logic [SUM_W-1:0]    frame_sum   = '0;
  logic [BYTE_W-1:0]   sum_low     = '0;
  logic [BYTE_W-1:0]   byte_buffer [BUF_DEPTH] = '{default: '0};

  // Channel results still owed by the parser, oldest first.
  channel_t pending_channels[$];

  bit idle_on = 1'b1;
  int n_bytes = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_mismatch = 0;

  function automatic void parse_rx_byte(input logic [7:0] rx, input logic gap);
    int       len;
    channel_t ch;
    len = rx;
    // A gap always restarts framing: treat the byte as a length byte.
    if (gap) begin
      if (len >= MIN_FRAME_LEN && len <= cfg_max_len &&
          len - FRAME_OVERHEAD <= BUF_DEPTH) begin
        fill_pos    = 0;
        payload_len = len - FRAME_OVERHEAD;
        frame_sum   = CHECK_INIT - rx;
        parse_phase = PH_DATA;
      end else begin
        parse_phase = PH_DISCARD;
      end
    end else begin
      case (parse_phase)
        PH_DATA: begin
          if (fill_pos < BUF_DEPTH) byte_buffer[fill_pos] = rx;
          fill_pos++;
          frame_sum = frame_sum - rx;
          if (fill_pos >= payload_len) parse_phase = PH_CHK_LO;
        end
        PH_CHK_LO: begin
          sum_low     = rx;
          parse_phase = PH_CHK_HI;
        end
        PH_CHK_HI: begin
          // Channel bytes never reach past the buffer: 2*14 < 32.
          if ({rx, sum_low} == frame_sum && byte_buffer[0] == cfg_cmd) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
              ch.index   = CHAN_W'(c);
              ch.value   = {byte_buffer[2 + 2 * c], byte_buffer[1 + 2 * c]};
              ch.is_last = (c == CHANNEL_COUNT - 1);
              pending_channels.push_back(ch);
            end
          end
          parse_phase = PH_DISCARD;
        end
        default: parse_phase = PH_DISCARD;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  // Drop tready in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  channel_t want;

  // Compare each accepted channel request with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_channels.size() == 0) begin
        $error("unexpected channel result, tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        n_mismatch++;
      end else begin
        want = pending_channels.pop_front();
        if (m_axis_tdata[CHAN_W-1:0] !== want.index) begin
          $error("channel_index: expected %0d, got %0d", want.index,
                 m_axis_tdata[CHAN_W-1:0]);
          n_mismatch++;
        end
        if (m_axis_tdata[CHAN_W +: VALUE_W] !== want.value) begin
          $error("channel_value: expected %h, got %h", want.value,
                 m_axis_tdata[CHAN_W +: VALUE_W]);
          n_mismatch++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("last_channel: expected %b, got %b", want.is_last, m_axis_tlast);
          n_mismatch++;
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one byte, optionally after an idle burst; update the mirror on accept.
  task automatic send_byte(input logic [7:0] rx, input logic gap);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= gap;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_rx_byte(rx, gap);
    n_bytes++;
  endtask

  // Build a frame of length byte len_byte; keep caps the bytes after it,
  // so a small keep truncates the frame. corrupt flips one checksum bit.
  task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] cmd_byte,
                            input bit corrupt, input int keep);
    logic [SUM_W-1:0]  sum;
    logic [BYTE_W-1:0] data;
    int                pay;
    int                k;
    pay = len_byte - FRAME_OVERHEAD;
    sum = CHECK_INIT - len_byte;
    send_byte(len_byte, 1'b1);
    for (k = 0; k < pay && k < keep; k++) begin
      case ($urandom_range(0, 5))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      if (k == 0) data = cmd_byte;
      sum = sum - data;
      send_byte(data, 1'b0);
    end
    if (corrupt) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    if (keep > pay) send_byte(sum[7:0], 1'b0);
    if (keep > pay + 1) send_byte(sum[15:8], 1'b0);
  endtask

  // Mostly short frames to keep the run brisk, now and then the largest allowed.
  function automatic int frame_length();
    int hi;
    hi = (cfg_max_len < 12) ? cfg_max_len : 12;
    if ($urandom_range(0, 5) == 0) return cfg_max_len;
    return $urandom_range(MIN_FRAME_LEN, hi);
  endfunction

  // Hold the input low until every owed channel has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_channels.size() != 0) @(posedge clk_i);
  endtask

  // Register write: a setup phase, then an access phase with pready high.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_MAX_LEN) cfg_max_len = data[MAXLEN_W-1:0];
    else if (addr == ADDR_CMD) cfg_cmd = data[BYTE_W-1:0];
    n_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stray byte, short and long length bytes, shortest frame, gap mid-frame,
  // bad checksum and a foreign command, all at the reset register values.
  task automatic test_directed_cases();
    send_byte(8'hA5, 1'b0);
    send_byte(8'd3, 1'b1);
    send_byte(8'd0, 1'b1);
    send_byte(8'd33, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Only the command byte is written: the channels read never-written entries as zero.
    send_frame(8'd4, cfg_cmd, 1'b0, FULL_FRAME);
    // Abandon this frame mid-payload; the next gap byte takes over.
    send_frame(8'd6, cfg_cmd, 1'b0, 2);
    send_frame(8'd5, cfg_cmd, 1'b0, FULL_FRAME);
    send_frame(8'd4, cfg_cmd, 1'b1, FULL_FRAME);
    send_frame(8'd4, cfg_cmd + 8'd1, 1'b0, FULL_FRAME);
  endtask

  // Mostly well-formed frames with random content, some with a bad checksum or a
  // foreign command; the rest is noise, bad length bytes and truncated frames.
  task automatic test_random_traffic(input int n);
    int          stop;
    int          len;
    logic [7:0]  b;
    stop = n_bytes + n;
    while (n_bytes < stop) begin
      len = frame_length();
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 4) == 0);
        1: begin
          if ($urandom_range(0, 1)) b = 8'($urandom_range(0, MIN_FRAME_LEN - 1));
          else b = 8'($urandom_range(cfg_max_len + 1, 255));
          send_byte(b, 1'b1);
        end
        2: send_frame(8'(len), cfg_cmd, 1'b0, $urandom_range(0, len - 2));
        default: begin
          b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : cfg_cmd;
          send_frame(8'(len), b, $urandom_range(0, 7) == 0, FULL_FRAME);
        end
      endcase
      if ($urandom_range(0, 15) == 0) drain_results();
    end
  endtask

  // Change both registers once the parser has gone quiet.
  task automatic test_register_settings(input int max_len, input int cmd);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(ADDR_MAX_LEN, max_len);
    write_reg(ADDR_CMD, cmd);
  endtask

  // Hold the sender until a whole channel burst has drained, then resume.
  task automatic test_drain_pause();
    send_frame(8'(frame_length()), cfg_cmd, 1'b0, FULL_FRAME);
    drain_results();
    send_frame(8'(frame_length()), cfg_cmd, 1'b0, FULL_FRAME);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(90);
    test_register_settings(MIN_FRAME_LEN, 0);
    test_random_traffic(70);
    test_register_settings(BUF_DEPTH, 255);
    test_random_traffic(70);
    test_drain_pause();
    test_register_settings($urandom_range(MIN_FRAME_LEN, BUF_DEPTH), $urandom_range(0, 255));
    test_random_traffic(70);
    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    test_register_settings($urandom_range(MIN_FRAME_LEN, BUF_DEPTH), $urandom_range(0, 255));
    test_random_traffic(50);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("frame parser: %0d bytes in, %0d channel results checked, %0d register writes",
             n_bytes, n_results, n_writes);
    $display("covered bad lengths, truncated, corrupt and foreign-command frames, stalls");
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
